/* hw/rtl/tis_pkg.sv */
// shared constants and codes for the tracked id slot table
`timescale 1ns / 1ps
`default_nettype none
package tis_pkg;

  localparam int unsigned SLOTS_DEFAULT = 8;
  localparam int unsigned ADDR_W        = 48;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned ENTRY_W       = ADDR_W + TIME_W;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd120000;

  localparam logic [1:0] OUTCOME_HIT     = 2'd0;
  localparam logic [1:0] OUTCOME_CLAIM   = 2'd1;
  localparam logic [1:0] OUTCOME_REPLACE = 2'd2;

  localparam logic ACTION_DETECT = 1'b0;
  localparam logic ACTION_COUNT  = 1'b1;

endpackage
`default_nettype wire

/* hw/rtl/tis_ram.sv */
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tis_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tracked_id_slot_table_top.sv */
// tracked id slot table: sequential slot scan with hit, claim or oldest replace, or an active count
`timescale 1ns / 1ps
`default_nettype none
// an accepted item passes the scan state, then the write state; no new item is taken
// until done is shown; the slot ram feeds one entry per cycle to the compare unit,
// then the write state writes back the chosen slot on a detect and raises done
// busy stays high until the cycle done is shown; done lasts one cycle, no receiver stall
// reset (synchronous, rst high) clears all slot valid bits, so every slot reads as zero,
// and loads the active window with 120000
module tracked_id_slot_table_top #(
  parameter int unsigned SLOTS = tis_pkg::SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action,
  input  wire logic [47:0] mac,
  input  wire logic [31:0] now_ms,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  output logic             done,
  output logic [2:0]       slot,
  output logic [1:0]       outcome,
  output logic [3:0]       active_count
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned AW = tis_pkg::ADDR_W;
  localparam int unsigned TW = tis_pkg::TIME_W;
  localparam int unsigned EW = tis_pkg::ENTRY_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  state_t          state;
  logic [TW-1:0]   active_window;
  logic            act_q;
  logic [AW-1:0]   mac_q;
  logic [TW-1:0]   now_q;
  logic [IW:0]     rd_idx;
  logic            proc_valid;
  logic [IW-1:0]   proc_idx;
  logic            proc_in_use;
  logic [SLOTS-1:0] valid;

  logic            hit_found;
  logic [IW-1:0]   hit_idx;
  logic            free_found;
  logic [IW-1:0]   free_idx;
  logic [TW-1:0]   min_time;
  logic [IW-1:0]   min_idx;
  logic [CW-1:0]   cnt;

  logic            rd_en;
  logic [EW-1:0]   rd_data;
  logic [AW-1:0]   e_addr;
  logic [TW-1:0]   e_time;
  logic [TW-1:0]   e_age;
  logic            e_lead;
  logic [IW-1:0]   chosen;
  logic [1:0]      chosen_outcome;
  logic            wr_en;
  logic [7:0]      chosen_w;
  logic [7:0]      cnt_w;

  assign busy  = (state != ST_IDLE);
  assign rd_en = (state == ST_SCAN) && (rd_idx < (IW + 1)'(SLOTS));

  // an entry never written since reset reads as zero
  assign e_addr = proc_in_use ? rd_data[EW-1:TW] : '0;
  assign e_time = proc_in_use ? rd_data[TW-1:0] : '0;
  assign e_age  = now_q - e_time;
  assign e_lead = (e_addr[AW-1:AW-8] != 8'd0);

  always_comb begin
    if (hit_found) begin
      chosen         = hit_idx;
      chosen_outcome = tis_pkg::OUTCOME_HIT;
    end else if (free_found) begin
      chosen         = free_idx;
      chosen_outcome = tis_pkg::OUTCOME_CLAIM;
    end else begin
      chosen         = min_idx;
      chosen_outcome = tis_pkg::OUTCOME_REPLACE;
    end
  end

  assign wr_en    = (state == ST_WRITE) && (act_q == tis_pkg::ACTION_DETECT);
  assign chosen_w = 8'(chosen);
  assign cnt_w    = 8'(cnt);

  tis_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(chosen),
    .wdata({mac_q, now_q}),
    .re   (rd_en),
    .raddr(rd_idx[IW-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[chosen] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active_window <= tis_pkg::WINDOW_RESET;
      proc_valid    <= 1'b0;
      done          <= 1'b0;
      slot          <= '0;
      outcome       <= '0;
      active_count  <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        active_window <= cfg_wdata;
      end
      proc_valid <= rd_en;
      if (rd_en) begin
        proc_idx    <= rd_idx[IW-1:0];
        proc_in_use <= valid[rd_idx[IW-1:0]];
        rd_idx      <= rd_idx + 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            act_q      <= action;
            mac_q      <= mac;
            now_q      <= now_ms;
            rd_idx     <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            cnt        <= '0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (proc_valid) begin
            if (!hit_found && (e_addr == mac_q)) begin
              hit_found <= 1'b1;
              hit_idx   <= proc_idx;
            end
            if (!free_found && !e_lead) begin
              free_found <= 1'b1;
              free_idx   <= proc_idx;
            end
            // strict less keeps the lowest index on equal times
            if ((proc_idx == '0) || (e_time < min_time)) begin
              min_time <= e_time;
              min_idx  <= proc_idx;
            end
            if (e_lead && (e_age < active_window)) begin
              cnt <= cnt + 1'b1;
            end
            if (proc_idx == IW'(SLOTS - 1)) begin
              state <= ST_WRITE;
            end
          end
        end
        ST_WRITE: begin
          done <= 1'b1;
          if (act_q == tis_pkg::ACTION_COUNT) begin
            slot         <= '0;
            outcome      <= tis_pkg::OUTCOME_HIT;
            active_count <= (cnt_w > 8'd15) ? 4'd15 : cnt_w[3:0];
          end else begin
            slot         <= chosen_w[2:0];
            outcome      <= chosen_outcome;
            active_count <= '0;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_after_write: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_WRITE))
    else $error("done without a write-back cycle");

  a_start_to_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_SCAN))
    else $error("accepted item did not start a scan");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> ((active_count == 4'd0) ||
              ((outcome == tis_pkg::OUTCOME_HIT) && (slot == 3'd0))))
    else $error("result mixes count and detect fields");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (outcome != 2'd3))
    else $error("illegal outcome code");

  a_no_write_on_scan: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !wr_en)
    else $error("slot write during scan");

endmodule
`default_nettype wire

/* sim/tracked_id_slot_table_top_tb.sv */
// testbench for the tracked id slot table: queue-fed driver, strobe monitor, table predictor
`timescale 1ns / 1ps
module tracked_id_slot_table_top_tb;

  localparam int unsigned TBL_SLOTS = tis_pkg::SLOTS_DEFAULT;

  typedef struct {
    logic        is_cfg;
    logic [31:0] wval;
    logic        act;
    logic [47:0] addr;
    logic [31:0] t;
    int unsigned idle_pct;
  } tbl_op_t;

  typedef struct packed {
    logic [2:0] slot;
    logic [1:0] outcome;
    logic [3:0] active_count;
  } slot_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        action = 1'b0;
  logic [47:0] mac = '0;
  logic [31:0] now_ms = '0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        busy;
  logic        done;
  logic [2:0]  slot;
  logic [1:0]  outcome;
  logic [3:0]  active_count;

  tbl_op_t     pending_ops[$];
  slot_res_t   slot_res_q[$];
  int unsigned mismatch_cnt = 0;
  int          in_flight = 0;

  // predictor copy of the table and the window register
  logic [47:0] tbl_addr [TBL_SLOTS];
  logic [31:0] tbl_time [TBL_SLOTS];
  logic [31:0] window_now = tis_pkg::WINDOW_RESET;

  tracked_id_slot_table_top #(.SLOTS(TBL_SLOTS)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .mac(mac),
    .now_ms(now_ms), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .slot(slot),
    .outcome(outcome), .active_count(active_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic slot_res_t lookup_or_count(logic act, logic [47:0] a, logic [31:0] t);
    slot_res_t   r;
    int unsigned cnt;
    int          hit_i;
    int          free_i;
    int          old_i;
    int          chosen;
    logic [1:0]  oc;
    logic [31:0] age;
    r = '0;
    if (act == tis_pkg::ACTION_COUNT) begin
      cnt = 0;
      for (int i = 0; i < TBL_SLOTS; i++) begin
        age = t - tbl_time[i];
        if (tbl_addr[i][47:40] != 8'h00 && age < window_now) cnt++;
      end
      r.active_count = (cnt > 15) ? 4'd15 : cnt[3:0];
      return r;
    end
    hit_i = -1;
    free_i = -1;
    old_i = 0;
    for (int i = 0; i < TBL_SLOTS; i++) begin
      if (hit_i < 0 && tbl_addr[i] == a) hit_i = i;
      if (free_i < 0 && tbl_addr[i][47:40] == 8'h00) free_i = i;
      // raw compare of stored times, ties keep the lowest index
      if (tbl_time[i] < tbl_time[old_i]) old_i = i;
    end
    if (hit_i >= 0) begin
      chosen = hit_i;
      oc = tis_pkg::OUTCOME_HIT;
    end else if (free_i >= 0) begin
      chosen = free_i;
      oc = tis_pkg::OUTCOME_CLAIM;
    end else begin
      chosen = old_i;
      oc = tis_pkg::OUTCOME_REPLACE;
    end
    tbl_addr[chosen] = a;
    tbl_time[chosen] = t;
    r.slot = chosen[2:0];
    r.outcome = oc;
    return r;
  endfunction

  task automatic push_item(logic act, logic [47:0] a, logic [31:0] t, int unsigned idle);
    tbl_op_t op;
    op = '{is_cfg: 1'b0, wval: '0, act: act, addr: a, t: t, idle_pct: idle};
    pending_ops.push_back(op);
  endtask

  task automatic push_cfg(logic [31:0] v);
    tbl_op_t op;
    op = '{is_cfg: 1'b1, wval: v, act: 1'b0, addr: '0, t: '0, idle_pct: 0};
    pending_ops.push_back(op);
  endtask

  // driver: presents items, writes the window only when nothing is in flight
  always @(posedge clk) begin
    logic    accepted;
    logic    nxt_start;
    logic    nxt_we;
    logic    load;
    tbl_op_t op;
    if (rst) begin
      for (int i = 0; i < TBL_SLOTS; i++) begin
        tbl_addr[i] = '0;
        tbl_time[i] = '0;
      end
      window_now = tis_pkg::WINDOW_RESET;
      in_flight = 0;
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      if (cfg_we) window_now = cfg_wdata;
      accepted = start && !busy;
      if (accepted) begin
        slot_res_q.push_back(lookup_or_count(action, mac, now_ms));
        in_flight++;
      end
      if (done) in_flight--;
      nxt_start = start && !accepted;
      nxt_we = 1'b0;
      load = 1'b0;
      if (!nxt_start && pending_ops.size() != 0) begin
        op = pending_ops[0];
        if (op.is_cfg) begin
          if (in_flight == 0) begin
            nxt_we = 1'b1;
            void'(pending_ops.pop_front());
          end
        end else if ($urandom_range(99) >= op.idle_pct) begin
          nxt_start = 1'b1;
          load = 1'b1;
          void'(pending_ops.pop_front());
        end
      end
      start <= nxt_start;
      cfg_we <= nxt_we;
      if (nxt_we) cfg_wdata <= op.wval;
      if (load) begin
        action <= op.act;
        mac <= op.addr;
        now_ms <= op.t;
      end
    end
  end

  // monitor: every strobe is compared with the oldest prediction
  always @(posedge clk) begin
    slot_res_t want;
    if (!rst && done) begin
      if (slot_res_q.size() == 0) begin
        if (mismatch_cnt < 10) $display("unexpected result: slot %0d outcome %0d count %0d",
                                         slot, outcome, active_count);
        mismatch_cnt++;
      end else begin
        want = slot_res_q.pop_front();
        if (slot !== want.slot || outcome !== want.outcome ||
            active_count !== want.active_count) begin
          if (mismatch_cnt < 10)
            $display("mismatch at %0t: slot %0d/%0d outcome %0d/%0d count %0d/%0d (exp/act)",
                     $realtime, want.slot, slot, want.outcome, outcome,
                     want.active_count, active_count);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [47:0] pool [12];
    logic [31:0] win_list [8];
    int unsigned idle_by_phase [4];
    logic [31:0] gen_t;
    logic [31:0] gen_last_t;
    logic [31:0] cnt_t;
    logic [31:0] win;
    logic [47:0] a;
    int unsigned step_max;
    int unsigned r;
    logic [31:0] slot_times [7];

    // directed: empty table, zero addresses, extremes, ties, wrap and window edge
    push_item(tis_pkg::ACTION_COUNT, 48'h0, 32'd0, 0);
    push_item(tis_pkg::ACTION_DETECT, 48'h0, 32'd5, 0);     // all-zero address hits empty slot
    push_item(tis_pkg::ACTION_DETECT, 48'h00_12_34_56_78_9A, 32'd6, 0);
    push_item(tis_pkg::ACTION_COUNT, 48'h0, 32'd10, 0);
    push_item(tis_pkg::ACTION_DETECT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
    slot_times = '{32'd100, 32'd100, 32'd50, 32'd50, 32'd200, 32'd300, 32'd400};
    for (int i = 0; i < 7; i++)
      push_item(tis_pkg::ACTION_DETECT, 48'h0100_0000_0000 + i, slot_times[i], 0);
    push_item(tis_pkg::ACTION_COUNT, 48'hFFFF_FFFF_FFFF, 32'd10, 0);  // wrapped age of max time
    push_item(tis_pkg::ACTION_COUNT, 48'h0, 32'd120049, 0);
    push_item(tis_pkg::ACTION_COUNT, 48'h0, 32'd120050, 0);           // exactly at the window
    push_item(tis_pkg::ACTION_DETECT, 48'h8000_0000_0001, 32'd500, 0); // oldest tie, lowest index
    push_item(tis_pkg::ACTION_DETECT, 48'h8000_0000_0002, 32'd501, 0);
    push_item(tis_pkg::ACTION_DETECT, 48'h0100_0000_0000, 32'd600, 0);
    push_item(tis_pkg::ACTION_DETECT, 48'h0, 32'd700, 0);             // replaced slot becomes free
    push_item(tis_pkg::ACTION_DETECT, 48'h55AA_55AA_55AA, 32'd800, 0);
    push_item(tis_pkg::ACTION_DETECT, 48'h0, 32'd900, 0);
    push_item(tis_pkg::ACTION_COUNT, 48'h0, 32'd1000, 0);

    win_list = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd50, 32'd120000, $urandom, 32'd1000,
                 tis_pkg::WINDOW_RESET};
    idle_by_phase = '{0, 46, 0, 14};
    gen_last_t = '0;
    for (int ph = 0; ph < 4; ph++) begin
      for (int sg = 0; sg < 2; sg++) begin
        win = win_list[ph * 2 + sg];
        push_cfg(win);
        for (int k = 0; k < 12; k++)
          pool[k] = {($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255, 1)),
                     8'($urandom), 32'($urandom)};
        case ($urandom_range(2))
          0: step_max = 3;
          1: step_max = 300;
          default: step_max = 60000;
        endcase
        // some segments start just short of the time wrap
        if ($urandom_range(1) == 1) gen_t = 32'hFFFF_FFFF - 32'($urandom_range(200000));
        else gen_t = $urandom;
        for (int n = 0; n < 150; n++) begin
          if ($urandom_range(3) == 0) begin
            case ($urandom_range(3))
              0: cnt_t = gen_t;
              1: cnt_t = gen_last_t + win - 32'd1 + 32'($urandom_range(2));
              2: cnt_t = gen_last_t - 32'd1;
              default: cnt_t = $urandom;
            endcase
            push_item(tis_pkg::ACTION_COUNT, 48'({$urandom, $urandom}), cnt_t,
                      idle_by_phase[ph]);
          end else begin
            if ($urandom_range(19) == 0) gen_t = $urandom;
            else gen_t = gen_t + 32'($urandom_range(step_max));
            r = $urandom_range(19);
            if (r == 0) a = 48'h0;
            else if (r == 1) a = 48'({$urandom, $urandom});
            else a = pool[$urandom_range(11)];
            gen_last_t = gen_t;
            push_item(tis_pkg::ACTION_DETECT, a, gen_t, idle_by_phase[ph]);
          end
        end
      end
    end

    wait (!rst);
    while (pending_ops.size() != 0 || start || cfg_we || slot_res_q.size() != 0)
      @(negedge clk);
    repeat (TBL_SLOTS + 8) @(negedge clk);
    if (mismatch_cnt == 0 && slot_res_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
